// File: rtl/epfa_pkg.sv
// Shared types and constants for the event polarity frame accumulator.
package epfa_pkg;

  // Command codes carried on the command port
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // Rendering constants
  localparam logic [7:0] GRAY_MID  = 8'd128;
  localparam logic [6:0] SCALE_NUM = 7'd127;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Result handed from the scaling unit to the controller
  typedef struct packed {
    logic       done;
    logic [7:0] gray;
  } scale_res_t;

endpackage

// File: rtl/epfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/epfa_scale.sv
// Two-lane restoring divider with half-to-even rounding that renders a gray level.
module epfa_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [7:0]              pos_count,
  input  logic [7:0]              neg_count,
  input  logic [7:0]              peak,
  output epfa_pkg::scale_res_t    res
);

  logic        run;
  logic        rnd;
  logic [2:0]  step;
  logic [14:0] div_sh;
  logic [7:0]  divisor;
  logic [14:0] rem_p;
  logic [14:0] rem_n;
  logic [7:0]  q_p;
  logic [7:0]  q_n;
  logic        ge_p;
  logic        ge_n;
  logic        up_p;
  logic        up_n;
  logic [8:0]  twice_p;
  logic [8:0]  twice_n;
  logic [7:0]  qr_p;
  logic [7:0]  qr_n;
  logic [8:0]  gray_full;

  // Compare each remainder against the shifted divisor
  assign ge_p = (rem_p >= div_sh);
  assign ge_n = (rem_n >= div_sh);

  // Round half to even: remainder stays below the divisor
  assign twice_p   = {rem_p[7:0], 1'b0};
  assign twice_n   = {rem_n[7:0], 1'b0};
  assign up_p      = (twice_p > {1'b0, divisor}) || ((twice_p == {1'b0, divisor}) && q_p[0]);
  assign up_n      = (twice_n > {1'b0, divisor}) || ((twice_n == {1'b0, divisor}) && q_n[0]);
  assign qr_p      = q_p + {7'd0, up_p};
  assign qr_n      = q_n + {7'd0, up_n};
  assign gray_full = {1'b0, epfa_pkg::GRAY_MID} + {1'b0, qr_p} - {1'b0, qr_n};

  // Sequence control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      rnd      <= 1'b0;
      step     <= 3'd0;
      res.done <= 1'b0;
    end else begin
      res.done <= rnd;
      rnd      <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        step <= 3'd7;
      end else if (run) begin
        step <= step - 3'd1;
        if (step == 3'd0) begin
          run <= 1'b0;
          rnd <= 1'b1;
        end
      end
      if (rnd) begin
        res.gray <= gray_full[7:0];
      end
    end
  end

  // Datapath: load numerators, then retire one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      rem_p   <= 15'(pos_count) * 15'(epfa_pkg::SCALE_NUM);
      rem_n   <= 15'(neg_count) * 15'(epfa_pkg::SCALE_NUM);
      div_sh  <= {peak, 7'd0};
      divisor <= peak;
      q_p     <= 8'd0;
      q_n     <= 8'd0;
    end else if (run) begin
      if (ge_p) begin
        rem_p <= rem_p - div_sh;
      end
      if (ge_n) begin
        rem_n <= rem_n - div_sh;
      end
      q_p    <= {q_p[6:0], ge_p};
      q_n    <= {q_n[6:0], ge_n};
      div_sh <= {1'b0, div_sh[14:1]};
    end
  end

endmodule

// File: rtl/event_polarity_frame_accumulator.sv
// Event add (in-frame pixels only): RAM read, then modify and write back.
// Pixel read: done strobes from S_FETCH for a neutral pixel, or after S_FETCH and S_DIV
// when the 8-step divider runs; the next command can be taken in the done cycle.
// Clear command and reset: a sweep over all MAX_WIDTH*MAX_HEIGHT entries (262144 at default
// size) zeroes the count RAM with busy high; configuration writes are taken anytime.
// Results are shown for one cycle on done; the receiver cannot stall.
module event_polarity_frame_accumulator #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [8:0] pos_x,
  input  logic [8:0] pos_y,
  input  logic       polarity,
  output logic       done,
  output logic [7:0] gray_level,
  output logic       touched,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVENT = 5'b00010,
    S_FETCH = 5'b00100,
    S_DIV   = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t               state;
  logic [9:0]           frame_width;
  logic [9:0]           frame_height;
  logic [7:0]           peak;
  logic [AW-1:0]        addr;
  logic                 pol_q;
  logic                 inside_q;
  logic [AW-1:0]        clr_addr;
  logic                 in_frame;
  logic [AW-1:0]        lin_idx;
  logic                 accept;
  logic [15:0]          rdata;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [15:0]          wdata;
  logic [7:0]           count_cur;
  logic [7:0]           count_next;
  logic                 scale_go;
  epfa_pkg::scale_res_t scale_res;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Frame bounds and linear pixel address
  assign in_frame = ({1'b0, pos_x} < frame_width) && (int'(pos_x) < MAX_WIDTH) &&
                    ({1'b0, pos_y} < frame_height) && (int'(pos_y) < MAX_HEIGHT);
  assign lin_idx  = AW'(32'(pos_y) * 32'(MAX_WIDTH) + 32'(pos_x));

  // Saturating increment of the selected polarity count
  assign count_cur  = pol_q ? rdata[15:8] : rdata[7:0];
  assign count_next = (count_cur == epfa_pkg::COUNT_MAX) ? count_cur : count_cur + 8'd1;

  // RAM write: clearing sweep or event write-back
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = rdata;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = 16'd0;
    end else if (state == S_EVENT) begin
      we = 1'b1;
      if (pol_q) begin
        wdata = {count_next, rdata[7:0]};
      end else begin
        wdata = {rdata[15:8], count_next};
      end
    end
  end

  assign scale_go = (state == S_FETCH) && inside_q && (peak != 8'd0);

  // Count RAM: positive count in the upper byte, negative in the lower
  epfa_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (lin_idx),
    .rdata (rdata)
  );

  epfa_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .go        (scale_go),
    .pos_count (rdata[15:8]),
    .neg_count (rdata[7:0]),
    .peak      (peak),
    .res       (scale_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 10'd512;
      frame_height <= 10'd512;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == epfa_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == epfa_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  // Transaction hold registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr     <= lin_idx;
      pol_q    <= polarity;
      inside_q <= in_frame;
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      peak     <= 8'd0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (command)
              epfa_pkg::CMD_ADD: begin
                if (in_frame) begin
                  state <= S_EVENT;
                end
              end
              epfa_pkg::CMD_READ: begin
                state <= S_FETCH;
              end
              epfa_pkg::CMD_CLEAR: begin
                state    <= S_CLEAR;
                clr_addr <= '0;
                peak     <= 8'd0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_EVENT: begin
          if (count_next > peak) begin
            peak <= count_next;
          end
          state <= S_IDLE;
        end
        S_FETCH: begin
          if (scale_go) begin
            state <= S_DIV;
          end else begin
            gray_level <= epfa_pkg::GRAY_MID;
            touched    <= 1'b0;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DIV: begin
          if (scale_res.done) begin
            gray_level <= scale_res.gray;
            touched    <= (scale_res.gray != epfa_pkg::GRAY_MID);
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/epfa_checker.sv
// Port-level checks for the event polarity frame accumulator, bound to the top level.
module epfa_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       done,
  input logic [7:0] gray_level,
  input logic       touched
);

  // Reset starts the clearing sweep
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  // A read keeps the block busy until its result
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == epfa_pkg::CMD_READ) |=> busy)
    else $error("read accepted without going busy");

  // No result directly after an accepted transaction
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result one cycle after acceptance");

  // Results are single-cycle strobes
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // Touched flags exactly the non-neutral gray values
  a_touched: assert property (@(posedge clk) disable iff (rst)
    done |-> (touched == (gray_level != epfa_pkg::GRAY_MID)))
    else $error("touched inconsistent with gray_level");

endmodule

bind event_polarity_frame_accumulator epfa_checker u_epfa_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .command    (command),
  .done       (done),
  .gray_level (gray_level),
  .touched    (touched)
);
